// ===== design/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== design/bres_pkg.sv =====
// package with widths, types and helpers of the line rasteriser
`timescale 1ns / 1ps
`default_nettype none

package bres_pkg;

  localparam int CANVAS_SIZE = 64;
  localparam int COORD_W     = 6;
  localparam int DELTA_W     = COORD_W + 1;
  localparam int ERR_W       = COORD_W + 2;
  localparam int CNT_W       = (CANVAS_SIZE > 2) ? $clog2(CANVAS_SIZE) : 1;
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_W       = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;

  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(CANVAS_SIZE - 1);
  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(CANVAS_SIZE - 1);

  // one classified line, ready to walk
  typedef struct packed {
    logic               y_is_major;
    logic               minor_dir_negative;
    logic [COORD_W-1:0] major_pos;
    logic [COORD_W-1:0] major_end;
    logic [COORD_W-1:0] minor_pos;
    logic [DELTA_W-1:0] major_delta;
    logic [DELTA_W-1:0] minor_delta;
  } bres_cmd_t;

  // walker status seen by the top level
  typedef struct packed {
    logic               active;
    logic               emit_last;
    logic [COORD_W-1:0] major_pos;
    logic [COORD_W-1:0] major_end;
  } bres_walk_status_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== design/bres_front.sv =====
// front end: takes line requests, clamps and classifies them into walk commands
`timescale 1ns / 1ps
`default_nettype none

module bres_front import bres_pkg::*; (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [COORD_W-1:0] start_x_i,
  input  logic [COORD_W-1:0] start_y_i,
  input  logic [COORD_W-1:0] end_x_i,
  input  logic [COORD_W-1:0] end_y_i,
  input  logic               fifo_full_i,
  output logic               push_o,
  output bres_cmd_t          cmd_o
);

  logic [COORD_W-1:0] ax, ay, bx, by;
  logic [COORD_W-1:0] min_end;
  logic               x_major;

  always_comb begin
    ax = clamp_coord(start_x_i);
    ay = clamp_coord(start_y_i);
    bx = clamp_coord(end_x_i);
    by = clamp_coord(end_y_i);
    x_major = abs_diff(ax, bx) > abs_diff(ay, by);

    cmd_o = '0;
    cmd_o.y_is_major = !x_major;
    if (x_major) begin
      if (ax < bx) begin
        cmd_o.major_pos = ax; cmd_o.major_end = bx; cmd_o.minor_pos = ay; min_end = by;
      end else begin
        cmd_o.major_pos = bx; cmd_o.major_end = ax; cmd_o.minor_pos = by; min_end = ay;
      end
    end else begin
      if (ay < by) begin
        cmd_o.major_pos = ay; cmd_o.major_end = by; cmd_o.minor_pos = ax; min_end = bx;
      end else begin
        cmd_o.major_pos = by; cmd_o.major_end = ay; cmd_o.minor_pos = bx; min_end = ax;
      end
    end
    cmd_o.major_delta        = {1'b0, cmd_o.major_end - cmd_o.major_pos};
    cmd_o.minor_delta        = {1'b0, abs_diff(cmd_o.minor_pos, min_end)};
    cmd_o.minor_dir_negative = min_end < cmd_o.minor_pos;
  end

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

endmodule

`default_nettype wire

// ===== design/bres_cmd_fifo.sv =====
// short command queue between front end and walker
`timescale 1ns / 1ps
`default_nettype none

module bres_cmd_fifo import bres_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bres_cmd_t push_data_i,
  input  logic      pop_i,
  output bres_cmd_t pop_data_o,
  output logic      full_o,
  output logic      empty_o,
  output logic [PTR_W:0] count_o
);

  bres_cmd_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;

  assign full_o     = cnt_q == (PTR_W + 1)'(FIFO_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign count_o    = cnt_q;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/bres_walk.sv =====
// back end: walks one line a pixel per cycle, while the output is not stalled, into the output register
`timescale 1ns / 1ps
`default_nettype none

module bres_walk import bres_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fifo_empty_i,
  input  bres_cmd_t          cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COORD_W-1:0] pixel_x_o,
  output logic [COORD_W-1:0] pixel_y_o,
  output logic               last_pixel_o,
  output bres_walk_status_t  status_o
);

  logic                      active_q, active_d;
  logic                      ymaj_q, neg_q;
  logic [COORD_W-1:0]        maj_q, maj_end_q, min_q;
  logic [DELTA_W-1:0]        maj_delta_q, min_delta_q;
  logic signed [ERR_W-1:0]   err_q, err_sum, err_next;
  logic [CNT_W-1:0]          cnt_q;
  logic                      out_valid_q, out_valid_d;
  logic [COORD_W-1:0]        px_q, py_q;
  logic                      last_q;
  logic                      is_last, emit, step_minor;

  always_comb begin
    is_last    = (maj_q == maj_end_q) || (cnt_q == CNT_MAX);
    emit       = active_q && (!out_valid_q || !out_stall_i);
    pop_o      = !active_q && !fifo_empty_i;
    err_sum    = err_q + $signed({1'b0, min_delta_q});
    // twice the error against the major delta, one bit wider
    step_minor = $signed({err_sum, 1'b0}) >= $signed({2'b00, maj_delta_q});
    err_next   = step_minor ? err_sum - $signed({1'b0, maj_delta_q}) : err_sum;

    active_d = active_q;
    if (pop_o) begin
      active_d = 1'b1;
    end else if (emit && is_last) begin
      active_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // walk state and pixel register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ymaj_q      <= cmd_i.y_is_major;
      neg_q       <= cmd_i.minor_dir_negative;
      maj_q       <= cmd_i.major_pos;
      maj_end_q   <= cmd_i.major_end;
      min_q       <= cmd_i.minor_pos;
      maj_delta_q <= cmd_i.major_delta;
      min_delta_q <= cmd_i.minor_delta;
      err_q       <= '0;
      cnt_q       <= '0;
    end else if (emit && !is_last) begin
      err_q <= err_next;
      cnt_q <= cnt_q + 1'b1;
      maj_q <= maj_q + 1'b1;
      if (step_minor) begin
        min_q <= neg_q ? min_q - 1'b1 : min_q + 1'b1;
      end
    end
    if (emit) begin
      px_q   <= ymaj_q ? min_q : maj_q;
      py_q   <= ymaj_q ? maj_q : min_q;
      last_q <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign last_pixel_o = last_q;

  assign status_o.active    = active_q;
  assign status_o.emit_last = emit && is_last;
  assign status_o.major_pos = maj_q;
  assign status_o.major_end = maj_end_q;

endmodule

`default_nettype wire

// ===== design/bresenham_line_rasterizer_core.sv =====
// top level of the line rasteriser: front end, command queue and pixel walker
// a request goes through the command queue and the walker state before its first pixel is in the output register
// throughput: one pixel per cycle while unstalled; a line gives major delta + 1 pixels
//   (1 to 64), and the walker loads its next line from the command queue only once idle
// the front end accepts requests while the two-entry command queue has room
// reset (rst_ni low, asynchronous) empties the queue and the walker, output not valid
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bresenham_line_rasterizer_core import bres_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // line request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [COORD_W-1:0] start_x_i,
  input  logic [COORD_W-1:0] start_y_i,
  input  logic [COORD_W-1:0] end_x_i,
  input  logic [COORD_W-1:0] end_y_i,
  // pixel channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COORD_W-1:0] pixel_x_o,
  output logic [COORD_W-1:0] pixel_y_o,
  output logic               last_pixel_o
);

  // front end to queue
  logic              push;
  bres_cmd_t         push_cmd;
  logic              fifo_full;
  // queue to walker
  logic              pop;
  bres_cmd_t         pop_cmd;
  logic              fifo_empty;
  logic [PTR_W:0]    fifo_count;
  bres_walk_status_t walk_status;

  // clamps coordinates, picks the major axis and orders the endpoints
  bres_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // decouples request acceptance from the pixel walk
  bres_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty),
    .count_o     (fifo_count)
  );

  // error-term walk, one pixel per cycle while the output is not stalled, into a registered output
  bres_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o),
    .status_o     (walk_status)
  );

  // queue occupancy never goes past its depth
  `ASSERT_NEVER(a_fifo_bound, clk_i, rst_ni, fifo_count > (PTR_W + 1)'(FIFO_DEPTH))
  // the walk never overruns the end of the major axis
  `ASSERT_NEVER(a_walk_in_range, clk_i, rst_ni,
                walk_status.active && (walk_status.major_pos > walk_status.major_end))
  // emitting the final pixel retires the line and shows it as last
  `ASSERT_ALWAYS(a_last_retires, clk_i, rst_ni,
                 walk_status.emit_last |=> (!walk_status.active && out_valid_o && last_pixel_o))

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the line rasteriser core with its own pixel predictor
module tb_top;
  import bres_pkg::*;

  typedef logic [COORD_W-1:0] coord_t;

  // one pixel as it leaves the block
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic   clk_i        = 1'b0;
  logic   rst_ni       = 1'b0;
  logic   in_valid_i   = 1'b0;
  logic   in_stall_o;
  coord_t start_x_i    = '0;
  coord_t start_y_i    = '0;
  coord_t end_x_i      = '0;
  coord_t end_y_i      = '0;
  logic   out_valid_o;
  logic   out_stall_i  = 1'b0;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_pixel_o;

  // pixels predicted for accepted line requests, oldest first
  pixel_t      pending_pixels[$];
  int unsigned mismatch_count = 0;

  // when set, that side runs without idle cycles
  bit steady_source = 1'b0;
  bit steady_sink   = 1'b0;

  always #2 clk_i = ~clk_i;

  bresenham_line_rasterizer_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

  // coordinates past the canvas edge are pinned to the last column or row
  function automatic coord_t limit_to_canvas(input coord_t v);
    return (int'(v) > CANVAS_SIZE - 1) ? coord_t'(CANVAS_SIZE - 1) : v;
  endfunction

  function automatic int coord_distance(input coord_t a, input coord_t b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  // walks the line the way the block should and queues every pixel
  function automatic void predict_line(input coord_t sx, input coord_t sy,
                                       input coord_t ex, input coord_t ey);
    coord_t ax, ay, bx, by;
    coord_t walk_pos, walk_end, side_pos, side_end;
    logic   steep, side_down;
    int     walk_span, side_span, err, n;
    pixel_t px;
    ax = limit_to_canvas(sx);
    ay = limit_to_canvas(sy);
    bx = limit_to_canvas(ex);
    by = limit_to_canvas(ey);
    // ties, the single point among them, walk along y
    steep = !(coord_distance(ax, bx) > coord_distance(ay, by));
    if (!steep) begin
      if (ax < bx) begin
        walk_pos = ax; walk_end = bx; side_pos = ay; side_end = by;
      end else begin
        walk_pos = bx; walk_end = ax; side_pos = by; side_end = ay;
      end
    end else begin
      if (ay < by) begin
        walk_pos = ay; walk_end = by; side_pos = ax; side_end = bx;
      end else begin
        walk_pos = by; walk_end = ay; side_pos = bx; side_end = ax;
      end
    end
    walk_span = int'(walk_end) - int'(walk_pos);
    side_span = coord_distance(side_pos, side_end);
    side_down = side_end < side_pos;
    err = 0;
    n = 0;
    forever begin
      px.last = (walk_pos == walk_end) || (n >= CANVAS_SIZE - 1);
      px.x    = steep ? side_pos : walk_pos;
      px.y    = steep ? walk_pos : side_pos;
      pending_pixels.push_back(px);
      n++;
      if (px.last) break;
      err += side_span;
      if (2 * err >= walk_span) begin
        err -= walk_span;
        side_pos = side_down ? side_pos - 1'b1 : side_pos + 1'b1;
      end
      walk_pos = walk_pos + 1'b1;
    end
  endfunction

  // presents one line request after a random gap (none when steady) and waits for its acceptance;
  // valid stays high on return so a following request can go out back to back
  task automatic send_line(input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    int unsigned gap;
    gap = steady_source ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    do @(posedge clk_i); while (in_stall_o);
    predict_line(sx, sy, ex, ey);
  endtask

  // drops valid and holds off until every predicted pixel has come out
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // random point within seven of c, kept on the canvas
  function automatic coord_t near_coord(input coord_t c);
    int t;
    t = int'(c) + int'($urandom_range(0, 14)) - 7;
    if (t < 0) t = 0;
    if (t > CANVAS_SIZE - 1) t = CANVAS_SIZE - 1;
    return coord_t'(t);
  endfunction

  // zero-length lines give one pixel, flagged last
  task automatic test_single_pixel_lines();
    send_line(6'd0, 6'd0, 6'd0, 6'd0);
    send_line(6'd63, 6'd63, 6'd63, 6'd63);
    send_line(6'd17, 6'd42, 6'd17, 6'd42);
  endtask

  // full-width rows and columns, both directions, requests back to back
  task automatic test_axis_lines();
    steady_source = 1'b1;
    send_line(6'd0, 6'd21, 6'd63, 6'd21);
    send_line(6'd63, 6'd40, 6'd0, 6'd40);
    send_line(6'd5, 6'd0, 6'd5, 6'd63);
    send_line(6'd58, 6'd63, 6'd58, 6'd0);
    steady_source = 1'b0;
  endtask

  // exact diagonals are ties and so walk along y
  task automatic test_diagonal_lines();
    send_line(6'd0, 6'd0, 6'd63, 6'd63);
    send_line(6'd63, 6'd0, 6'd0, 6'd63);
    send_line(6'd0, 6'd63, 6'd63, 6'd0);
  endtask

  // one line in seven of the eight octants plus the two lines either side of a tie
  task automatic test_octant_lines();
    send_line(6'd10, 6'd10, 6'd40, 6'd20);
    send_line(6'd40, 6'd20, 6'd10, 6'd10);
    send_line(6'd10, 6'd20, 6'd40, 6'd10);
    send_line(6'd40, 6'd10, 6'd10, 6'd20);
    send_line(6'd10, 6'd10, 6'd20, 6'd40);
    send_line(6'd20, 6'd40, 6'd10, 6'd10);
    send_line(6'd20, 6'd10, 6'd10, 6'd40);
    send_line(6'd0, 6'd0, 6'd63, 6'd62);
    send_line(6'd0, 6'd0, 6'd62, 6'd63);
  endtask

  // mostly free lines, mixed with short ones and with rows, columns and diagonals
  task automatic test_random_lines();
    coord_t sx, sy, ex, ey;
    int     pick, shifted;
    for (int i = 0; i < 210; i++) begin
      // change the idling pattern every thirty requests
      if (i % 30 == 0) begin
        steady_source = ($urandom_range(0, 3) == 0);
        steady_sink   = ($urandom_range(0, 3) == 0);
      end
      // halfway through, let the block run completely dry once
      if (i == 105) wait_for_drain();
      sx   = coord_t'($urandom_range(0, CANVAS_SIZE - 1));
      sy   = coord_t'($urandom_range(0, CANVAS_SIZE - 1));
      ex   = coord_t'($urandom_range(0, CANVAS_SIZE - 1));
      ey   = coord_t'($urandom_range(0, CANVAS_SIZE - 1));
      pick = $urandom_range(0, 9);
      if (pick >= 6 && pick < 9) begin
        ex = near_coord(sx);
        ey = near_coord(sy);
      end else if (pick == 9) begin
        case ($urandom_range(0, 2))
          0: ex = sx;
          1: ey = sy;
          default: begin
            shifted = int'(sy) + int'(ex) - int'(sx);
            if (shifted >= 0 && shifted < CANVAS_SIZE) ey = coord_t'(shifted);
            else ex = sx;
          end
        endcase
      end
      send_line(sx, sy, ex, ey);
    end
    steady_source = 1'b0;
    steady_sink   = 1'b0;
  endtask

  // pixel side stall: a fresh hold-off for every pixel
  initial begin : drive_pixel_stall
    int unsigned hold;
    forever begin
      hold = steady_sink ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // every pixel taken from the block must match the oldest prediction
  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: pixel expected none actual (%0d,%0d) last %0d",
                 $realtime, pixel_x_o, pixel_y_o, last_pixel_o);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_x_o !== want.x) begin
          mismatch_count++;
          $display("%0t: pixel_x expected %0d actual %0d", $realtime, want.x, pixel_x_o);
        end
        if (pixel_y_o !== want.y) begin
          mismatch_count++;
          $display("%0t: pixel_y expected %0d actual %0d", $realtime, want.y, pixel_y_o);
        end
        if (last_pixel_o !== want.last) begin
          mismatch_count++;
          $display("%0t: last_pixel expected %0d actual %0d", $realtime, want.last,
                   last_pixel_o);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_pixel_lines();
    test_axis_lines();
    test_diagonal_lines();
    test_octant_lines();
    test_random_lines();
    wait_for_drain();
    // run on so that a stray extra pixel would still be caught
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== bresenham_line_rasterizer_core.f =====
+incdir+design
design/bres_pkg.sv
design/bres_front.sv
design/bres_cmd_fifo.sv
design/bres_walk.sv
design/bresenham_line_rasterizer_core.sv
tb/tb_top.sv
